>>> hw/rtl/lrupb_pkg.sv
`timescale 1ns / 1ps

package lrupb_pkg;

  // Table geometry.
  localparam int unsigned FRAME_COUNT = 16;
  localparam int unsigned PIN_BITS    = 8;
  localparam int unsigned SLOT_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int unsigned REC_W       = SLOT_W;

  // Fixed field widths.
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned OSLOT_W = 4;
  localparam int unsigned CFG_W  = 5;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
  localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_NEW_PAGE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FETCH      = 3'd1;
  localparam logic [OP_W-1:0] OP_UNPIN      = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH_PAGE = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH_ALL  = 3'd4;

  // Result action codes.
  localparam logic [ACT_W-1:0] ACT_WRITE_BACK = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ_IN    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DONE       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ERROR      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DISK_FLUSH = 3'd4;

  // Register index of frames_in_use.
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // One frame entry as held in the table memory.
  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [PIN_BITS-1:0] pins;
    logic [REC_W-1:0]    rec;
  } entry_t;

endpackage

>>> hw/rtl/lru_pinned_page_buffer_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata: page_number; tuser: operation, mark_dirty
// m_axis    out        tdata: page_out, slot; tuser: action, hit; tlast: last
// apb       in/out     register 0 at byte 0: frames_in_use
//
// A request takes a lookup pass over the frame memory and, when it changes
// recency, an update pass as well, both through the single read and single
// write memory port. Flush all visits each slot and reads only the dirty ones.
// Reset clears valid and dirty flags at once; no clearing pass is needed.
// A stalled result output holds the block in place until it is taken.
module lru_pinned_page_buffer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] page_number
  input  logic [3:0]  s_axis_tuser,  // [2:0] operation, [3] mark_dirty
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] page_out, [35:32] slot, [39:36] zero
  output logic [3:0]  m_axis_tuser,  // [2:0] action, [3] hit
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N  = lrupb_pkg::FRAME_COUNT;
  localparam int unsigned SW = lrupb_pkg::SLOT_W;
  localparam int unsigned CW = lrupb_pkg::CNT_W;
  localparam int unsigned PB = lrupb_pkg::PIN_BITS;
  localparam int unsigned RW = lrupb_pkg::REC_W;
  localparam int unsigned AW = lrupb_pkg::ACT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_WB, ST_UPD, ST_RESP, ST_FA_RD, ST_FA_CHK
  } state_e;

  typedef enum logic [1:0] {
    UK_TOUCH, UK_OCC_FREE, UK_OCC_VICT
  } upd_kind_e;

  state_e    state_q;
  upd_kind_e kind_q;

  // Frame table memory and per-slot flags.
  lrupb_pkg::entry_t mem [N];
  lrupb_pkg::entry_t rdata_q;
  logic [N-1:0]      valid_q;
  logic [N-1:0]      mod_q;
  logic [lrupb_pkg::CFG_W-1:0] frames_q;

  // Request registers.
  logic [lrupb_pkg::OP_W-1:0]   op_q;
  logic [lrupb_pkg::PAGE_W-1:0] page_q;
  logic                         dirty_q;

  // Walk counter and read pipeline.
  logic [CW-1:0] idx_q;
  logic          pv_q;
  logic [SW-1:0] pidx_q;

  // Lookup results.
  logic          hit_f_q, free_f_q, vic_f_q;
  logic [SW-1:0] hit_s_q, free_s_q, vic_s_q;
  logic [PB-1:0] hit_pins_q;
  logic [RW-1:0] hit_rec_q, vic_rec_q;
  logic [lrupb_pkg::PAGE_W-1:0] vic_page_q;
  logic [CW-1:0] used_q;

  // Planned update and final result.
  logic [SW-1:0] tgt_q;
  logic [RW-1:0] ref_rec_q;
  logic [PB-1:0] new_pins_q;
  logic          new_mod_q;
  logic [AW-1:0] res_act_q;
  logic [lrupb_pkg::PAGE_W-1:0] res_page_q;
  logic [SW-1:0] res_slot_q;
  logic          res_hit_q;

  // Output register.
  logic          out_vld_q;
  logic [AW-1:0] out_act_q;
  logic [lrupb_pkg::PAGE_W-1:0] out_page_q;
  logic [SW-1:0] out_slot_q;
  logic          out_hit_q;
  logic          out_last_q;

  logic          can_emit;
  logic          emit_w;
  logic [SW-1:0] idx_s;
  logic          idx_end;
  logic          rd_en;
  logic          we;
  lrupb_pkg::entry_t wd;
  logic [CW-1:0] cap;
  logic          cfg_we;

  assign can_emit = !out_vld_q || m_axis_tready;
  assign emit_w   = can_emit &&
                    (state_q == ST_WB || state_q == ST_RESP || state_q == ST_FA_CHK);
  assign idx_s    = idx_q[SW-1:0];
  assign idx_end  = (idx_q == CW'(N));

  // Effective capacity, clamped to one through the frame count.
  always_comb begin
    if (frames_q == '0) begin
      cap = CW'(1);
    end else if (32'(frames_q) > N) begin
      cap = CW'(N);
    end else begin
      cap = CW'(frames_q);
    end
  end

  // Memory read issue.
  always_comb begin
    unique case (state_q)
      ST_SCAN, ST_UPD: rd_en = !idx_end;
      ST_FA_RD:        rd_en = !idx_end && valid_q[idx_s] && mod_q[idx_s];
      default:         rd_en = 1'b0;
    endcase
  end

  // Write-back of the update pass: one slot a cycle, written from the registered read data.
  always_comb begin
    we = (state_q == ST_UPD) && pv_q && ((pidx_q == tgt_q) || valid_q[pidx_q]);
    wd = rdata_q;
    if (pidx_q == tgt_q) begin
      wd.page = page_q;
      wd.pins = new_pins_q;
      wd.rec  = '0;
    end else begin
      unique case (kind_q)
        UK_TOUCH: begin
          if (rdata_q.rec < ref_rec_q) begin
            wd.rec = rdata_q.rec + RW'(1);
          end
        end
        UK_OCC_FREE: wd.rec = rdata_q.rec + RW'(1);
        UK_OCC_VICT: begin
          if (!(rdata_q.rec > ref_rec_q)) begin
            wd.rec = rdata_q.rec + RW'(1);
          end
        end
        default: wd.rec = rdata_q.rec;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[idx_s];
    end
    if (we) begin
      mem[pidx_q] <= wd;
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lrupb_pkg::REG_FRAMES_IN_USE);
  assign prdata = (paddr[2] == lrupb_pkg::REG_FRAMES_IN_USE) ?
                  32'(frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupb_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      frames_q <= pwdata[lrupb_pkg::CFG_W-1:0];
    end
  end

  // Stream ports.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, lrupb_pkg::OSLOT_W'(out_slot_q), out_page_q};
  assign m_axis_tuser  = {out_hit_q, out_act_q};
  assign m_axis_tlast  = out_last_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= UK_TOUCH;
      valid_q    <= '0;
      mod_q      <= '0;
      out_vld_q  <= 1'b0;
      pv_q       <= 1'b0;
      idx_q      <= '0;
      op_q       <= '0;
      page_q     <= '0;
      dirty_q    <= 1'b0;
      pidx_q     <= '0;
      hit_f_q    <= 1'b0;
      free_f_q   <= 1'b0;
      vic_f_q    <= 1'b0;
      hit_s_q    <= '0;
      free_s_q   <= '0;
      vic_s_q    <= '0;
      hit_pins_q <= '0;
      hit_rec_q  <= '0;
      vic_rec_q  <= '0;
      vic_page_q <= '0;
      used_q     <= '0;
      tgt_q      <= '0;
      ref_rec_q  <= '0;
      new_pins_q <= '0;
      new_mod_q  <= 1'b0;
      res_act_q  <= '0;
      res_page_q <= '0;
      res_slot_q <= '0;
      res_hit_q  <= 1'b0;
      out_act_q  <= '0;
      out_page_q <= '0;
      out_slot_q <= '0;
      out_hit_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      // The output empties when taken, unless a new result loads this cycle.
      if (out_vld_q && m_axis_tready && !emit_w) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= s_axis_tuser[2:0];
            page_q   <= s_axis_tdata;
            dirty_q  <= s_axis_tuser[3];
            idx_q    <= '0;
            pv_q     <= 1'b0;
            hit_f_q  <= 1'b0;
            free_f_q <= 1'b0;
            vic_f_q  <= 1'b0;
            used_q   <= '0;
            if (s_axis_tuser[2:0] == lrupb_pkg::OP_FLUSH_ALL) begin
              state_q <= ST_FA_RD;
            end else if (s_axis_tuser[2:0] > lrupb_pkg::OP_FLUSH_ALL) begin
              res_act_q  <= lrupb_pkg::ACT_DONE;
              res_page_q <= s_axis_tdata;
              res_slot_q <= '0;
              res_hit_q  <= 1'b0;
              state_q    <= ST_RESP;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        // Lookup pass: match, fill count, lowest free slot and LRU victim.
        ST_SCAN: begin
          pv_q   <= !idx_end;
          pidx_q <= idx_s;
          if (!idx_end) begin
            idx_q <= idx_q + CW'(1);
          end
          if (pv_q) begin
            if (valid_q[pidx_q]) begin
              used_q <= used_q + CW'(1);
              if (rdata_q.page == page_q && !hit_f_q) begin
                hit_f_q    <= 1'b1;
                hit_s_q    <= pidx_q;
                hit_pins_q <= rdata_q.pins;
                hit_rec_q  <= rdata_q.rec;
              end
              if (rdata_q.pins == '0 && (!vic_f_q || rdata_q.rec > vic_rec_q)) begin
                vic_f_q    <= 1'b1;
                vic_s_q    <= pidx_q;
                vic_rec_q  <= rdata_q.rec;
                vic_page_q <= rdata_q.page;
              end
            end else if (!free_f_q) begin
              free_f_q <= 1'b1;
              free_s_q <= pidx_q;
            end
          end else if (idx_end) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          idx_q      <= '0;
          pv_q       <= 1'b0;
          res_page_q <= page_q;
          unique case (op_q)
            lrupb_pkg::OP_NEW_PAGE, lrupb_pkg::OP_FETCH: begin
              if (hit_f_q) begin
                kind_q     <= UK_TOUCH;
                tgt_q      <= hit_s_q;
                ref_rec_q  <= hit_rec_q;
                res_slot_q <= hit_s_q;
                res_hit_q  <= 1'b1;
                if (op_q == lrupb_pkg::OP_NEW_PAGE) begin
                  new_pins_q <= lrupb_pkg::PIN_ONE;
                  new_mod_q  <= 1'b0;
                  res_act_q  <= lrupb_pkg::ACT_READ_IN;
                end else begin
                  new_pins_q <= (hit_pins_q == lrupb_pkg::PIN_MAX) ?
                                hit_pins_q : hit_pins_q + PB'(1);
                  new_mod_q  <= mod_q[hit_s_q];
                  res_act_q  <= lrupb_pkg::ACT_DONE;
                end
                state_q <= ST_UPD;
              end else if (used_q < cap && free_f_q) begin
                kind_q     <= UK_OCC_FREE;
                tgt_q      <= free_s_q;
                new_pins_q <= lrupb_pkg::PIN_ONE;
                new_mod_q  <= 1'b0;
                res_act_q  <= lrupb_pkg::ACT_READ_IN;
                res_slot_q <= free_s_q;
                res_hit_q  <= 1'b0;
                state_q    <= ST_UPD;
              end else if (vic_f_q) begin
                kind_q     <= UK_OCC_VICT;
                tgt_q      <= vic_s_q;
                ref_rec_q  <= vic_rec_q;
                new_pins_q <= lrupb_pkg::PIN_ONE;
                new_mod_q  <= 1'b0;
                res_act_q  <= lrupb_pkg::ACT_READ_IN;
                res_slot_q <= vic_s_q;
                res_hit_q  <= 1'b0;
                state_q    <= mod_q[vic_s_q] ? ST_WB : ST_UPD;
              end else begin
                res_act_q  <= lrupb_pkg::ACT_ERROR;
                res_slot_q <= '0;
                res_hit_q  <= 1'b0;
                state_q    <= ST_RESP;
              end
            end
            lrupb_pkg::OP_UNPIN: begin
              res_act_q <= lrupb_pkg::ACT_DONE;
              if (hit_f_q) begin
                kind_q     <= UK_TOUCH;
                tgt_q      <= hit_s_q;
                ref_rec_q  <= hit_rec_q;
                new_pins_q <= (hit_pins_q == '0) ? hit_pins_q : hit_pins_q - PB'(1);
                new_mod_q  <= mod_q[hit_s_q] | dirty_q;
                res_slot_q <= hit_s_q;
                res_hit_q  <= 1'b1;
                state_q    <= ST_UPD;
              end else begin
                res_slot_q <= '0;
                res_hit_q  <= 1'b0;
                state_q    <= ST_RESP;
              end
            end
            lrupb_pkg::OP_FLUSH_PAGE: begin
              state_q <= ST_RESP;
              if (hit_f_q) begin
                mod_q[hit_s_q] <= 1'b0;
                res_act_q      <= lrupb_pkg::ACT_WRITE_BACK;
                res_slot_q     <= hit_s_q;
                res_hit_q      <= 1'b1;
              end else begin
                res_act_q  <= lrupb_pkg::ACT_DONE;
                res_slot_q <= '0;
                res_hit_q  <= 1'b0;
              end
            end
            default: begin
              res_act_q  <= lrupb_pkg::ACT_DONE;
              res_slot_q <= '0;
              res_hit_q  <= 1'b0;
              state_q    <= ST_RESP;
            end
          endcase
        end

        // Write-back of a dirty victim ahead of the read-in.
        ST_WB: begin
          if (can_emit) begin
            out_vld_q  <= 1'b1;
            out_act_q  <= lrupb_pkg::ACT_WRITE_BACK;
            out_page_q <= vic_page_q;
            out_slot_q <= vic_s_q;
            out_hit_q  <= 1'b0;
            out_last_q <= 1'b0;
            state_q    <= ST_UPD;
          end
        end

        // Update pass: recency ranks and the target entry are rewritten.
        ST_UPD: begin
          pv_q   <= !idx_end;
          pidx_q <= idx_s;
          if (!idx_end) begin
            idx_q <= idx_q + CW'(1);
          end else if (!pv_q) begin
            valid_q[tgt_q] <= 1'b1;
            mod_q[tgt_q]   <= new_mod_q;
            state_q        <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (can_emit) begin
            out_vld_q  <= 1'b1;
            out_act_q  <= res_act_q;
            out_page_q <= res_page_q;
            out_slot_q <= res_slot_q;
            out_hit_q  <= res_hit_q;
            out_last_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end

        // Flush all: visit each slot, read only the dirty ones.
        ST_FA_RD: begin
          if (idx_end) begin
            res_act_q  <= lrupb_pkg::ACT_DISK_FLUSH;
            res_page_q <= '0;
            res_slot_q <= '0;
            res_hit_q  <= 1'b0;
            state_q    <= ST_RESP;
          end else if (valid_q[idx_s] && mod_q[idx_s]) begin
            state_q <= ST_FA_CHK;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end

        ST_FA_CHK: begin
          if (can_emit) begin
            out_vld_q    <= 1'b1;
            out_act_q    <= lrupb_pkg::ACT_WRITE_BACK;
            out_page_q   <= rdata_q.page;
            out_slot_q   <= idx_s;
            out_hit_q    <= 1'b0;
            out_last_q   <= 1'b0;
            mod_q[idx_s] <= 1'b0;
            idx_q        <= idx_q + CW'(1);
            state_q      <= ST_FA_RD;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_RANDOM = 170;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 120;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] page;
    logic        dirty;
    bit          is_cfg;
    logic [4:0]  cfg_val;
    bit          drain;
  } request_t;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] page;
    logic [3:0]  slot;
    logic        hit;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_pinned_page_buffer_table u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted frame table.
  logic        fv_valid [lrupb_pkg::FRAME_COUNT];
  logic [31:0] fv_page  [lrupb_pkg::FRAME_COUNT];
  int unsigned fv_pins  [lrupb_pkg::FRAME_COUNT];
  logic        fv_dirty [lrupb_pkg::FRAME_COUNT];
  int unsigned fv_rank  [lrupb_pkg::FRAME_COUNT];
  int unsigned pool_limit = 16;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       error_count = 0;
  int       phase = 0;
  int       quiet_cycles = 0;
  int       tail_wait = 0;
  bit       stim_done = 0;
  bit       apb_busy = 0;
  logic [31:0] live_pages[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_result(logic [2:0] a, logic [31:0] p, int s, logic h,
                                      logic l);
    result_t r;
    r.action = a; r.page = p; r.slot = 4'(s); r.hit = h; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void promote(int s);
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
      if (i != s && fv_valid[i] && fv_rank[i] < fv_rank[s]) fv_rank[i]++;
    fv_rank[s] = 0;
  endfunction

  // Picks a frame for a new page, writing back the victim if dirty; -1 if all pinned.
  function automatic int claim_frame();
    int used = 0;
    int free_idx = -1;
    int victim = -1;
    int cap;
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++) begin
      if (fv_valid[i]) used++;
      else if (free_idx < 0) free_idx = i;
    end
    cap = pool_limit < 1 ? 1 : (pool_limit > lrupb_pkg::FRAME_COUNT ?
                                lrupb_pkg::FRAME_COUNT : pool_limit);
    if (used < cap && free_idx >= 0) return free_idx;
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
      if (fv_valid[i] && fv_pins[i] == 0 &&
          (victim < 0 || fv_rank[i] > fv_rank[victim])) victim = i;
    if (victim < 0) return -1;
    if (fv_dirty[victim])
      push_result(lrupb_pkg::ACT_WRITE_BACK, fv_page[victim], victim, 0, 0);
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
      if (i != victim && fv_valid[i] && fv_rank[i] > fv_rank[victim]) fv_rank[i]--;
    fv_valid[victim] = 0;
    fv_dirty[victim] = 0;
    return victim;
  endfunction

  function automatic void predict_table(request_t rq);
    int s = -1;
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
      if (s < 0 && fv_valid[i] && fv_page[i] == rq.page) s = i;
    case (rq.op)
      lrupb_pkg::OP_NEW_PAGE, lrupb_pkg::OP_FETCH: begin
        if (s >= 0) begin
          if (rq.op == lrupb_pkg::OP_NEW_PAGE) begin
            fv_pins[s] = 1; fv_dirty[s] = 0;
          end else if (fv_pins[s] < lrupb_pkg::PIN_MAX) begin
            fv_pins[s]++;
          end
          promote(s);
          push_result(rq.op == lrupb_pkg::OP_NEW_PAGE ? lrupb_pkg::ACT_READ_IN :
                      lrupb_pkg::ACT_DONE, rq.page, s, 1, 1);
        end else begin
          s = claim_frame();
          if (s < 0) begin
            push_result(lrupb_pkg::ACT_ERROR, rq.page, 0, 0, 1);
          end else begin
            for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
              if (fv_valid[i]) fv_rank[i]++;
            fv_valid[s] = 1; fv_page[s] = rq.page; fv_pins[s] = 1;
            fv_dirty[s] = 0; fv_rank[s] = 0;
            push_result(lrupb_pkg::ACT_READ_IN, rq.page, s, 0, 1);
          end
        end
      end
      lrupb_pkg::OP_UNPIN: begin
        if (s < 0) push_result(lrupb_pkg::ACT_DONE, rq.page, 0, 0, 1);
        else begin
          if (fv_pins[s] > 0) fv_pins[s]--;
          fv_dirty[s] |= rq.dirty;
          promote(s);
          push_result(lrupb_pkg::ACT_DONE, rq.page, s, 1, 1);
        end
      end
      lrupb_pkg::OP_FLUSH_PAGE: begin
        if (s < 0) push_result(lrupb_pkg::ACT_DONE, rq.page, 0, 0, 1);
        else begin
          fv_dirty[s] = 0;
          push_result(lrupb_pkg::ACT_WRITE_BACK, rq.page, s, 1, 1);
        end
      end
      lrupb_pkg::OP_FLUSH_ALL: begin
        for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++)
          if (fv_valid[i] && fv_dirty[i]) begin
            push_result(lrupb_pkg::ACT_WRITE_BACK, fv_page[i], i, 0, 0);
            fv_dirty[i] = 0;
          end
        push_result(lrupb_pkg::ACT_DISK_FLUSH, 32'd0, 0, 0, 1);
      end
      default: push_result(lrupb_pkg::ACT_DONE, rq.page, 0, 0, 1);
    endcase
  endfunction

  function automatic void add_req(logic [2:0] op, logic [31:0] page, logic dirty);
    request_t r;
    r.op = op; r.page = page; r.dirty = dirty; r.is_cfg = 0; r.cfg_val = 0; r.drain = 0;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_cfg(logic [4:0] v);
    request_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.cfg_val = v;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_drain();
    request_t r;
    r = '{default: '0};
    r.drain = 1;
    pending_reqs.push_back(r);
  endfunction

  // Page ids come mostly from a small working set so that hits and evictions occur.
  function automatic logic [31:0] pick_page();
    int c = $urandom_range(0, 9);
    if (c < 7 && live_pages.size() > 0) return live_pages[$urandom_range(0, live_pages.size() - 1)];
    if (c < 9) return 32'($urandom_range(0, 23));
    return $urandom;
  endfunction

  // Stimulus program.
  initial begin
    logic [31:0] p;
    int r;
    add_cfg(5'd16);
    add_req(lrupb_pkg::OP_NEW_PAGE, 32'hFFFF_FFFF, 0);
    add_req(lrupb_pkg::OP_NEW_PAGE, 32'h0000_0000, 0);
    add_req(lrupb_pkg::OP_FETCH, 32'hFFFF_FFFF, 0);
    add_req(lrupb_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1);
    add_req(lrupb_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1);
    add_req(lrupb_pkg::OP_UNPIN, 32'hFFFF_FFFF, 0);
    add_req(lrupb_pkg::OP_FLUSH_PAGE, 32'h0000_0000, 0);
    add_req(lrupb_pkg::OP_UNPIN, 32'hA5A5_5A5A, 1);
    add_req(lrupb_pkg::OP_FLUSH_PAGE, 32'h5A5A_A5A5, 0);
    add_req(lrupb_pkg::OP_NEW_PAGE, 32'h0000_0000, 0);
    add_req(lrupb_pkg::OP_FLUSH_ALL, 32'h0, 0);
    add_req(3'd5, 32'h1234_5678, 1);
    add_req(3'd6, 32'h8765_4321, 0);
    add_req(3'd7, 32'hFFFF_FFFF, 1);
    add_drain();
    // Capacity of one: a fetch evicts an unpinned frame, then dirty unpins and repeat fetches.
    add_cfg(5'd1);
    add_req(lrupb_pkg::OP_FETCH, 32'd100, 0);
    add_req(lrupb_pkg::OP_UNPIN, 32'd0, 1);
    add_req(lrupb_pkg::OP_UNPIN, 32'd0, 1);
    add_req(lrupb_pkg::OP_FETCH, 32'd100, 0);
    add_req(lrupb_pkg::OP_FETCH, 32'd100, 0);
    add_drain();
    add_cfg(5'd0);
    add_req(lrupb_pkg::OP_NEW_PAGE, 32'd200, 0);
    add_drain();
    add_cfg(5'd31);
    // Pin count saturation.
    for (int i = 0; i < 260; i++) add_req(lrupb_pkg::OP_FETCH, 32'd7, 0);
    add_drain();
    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k % 40 == 39) begin
        add_drain();
        r = $urandom_range(0, 3);
        add_cfg(r == 0 ? 5'd1 : r == 1 ? 5'd16 : r == 2 ? 5'd31 : 5'($urandom_range(0, 31)));
      end
      p = pick_page();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_req(lrupb_pkg::OP_FETCH, p, 0);
        if ($urandom_range(0, 2) != 0) add_req(lrupb_pkg::OP_UNPIN, p, 1'($urandom));
      end else if (r < 40) begin
        add_req(lrupb_pkg::OP_NEW_PAGE, p, 0);
      end else if (r < 75) begin
        add_req(lrupb_pkg::OP_UNPIN, p, 1'($urandom));
      end else if (r < 87) begin
        add_req(lrupb_pkg::OP_FLUSH_PAGE, p, 0);
      end else if (r < 95) begin
        add_req(lrupb_pkg::OP_FLUSH_ALL, $urandom, 1'($urandom));
      end else begin
        add_req(3'($urandom_range(5, 7)), $urandom, 1'($urandom));
      end
      if (live_pages.size() < 20) live_pages.push_back(p);
    end
    add_drain();
  end

  initial begin
    for (int i = 0; i < lrupb_pkg::FRAME_COUNT; i++) begin
      fv_valid[i] = 0; fv_dirty[i] = 0; fv_page[i] = 0; fv_pins[i] = 0; fv_rank[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idling phase advances with progress through the request list.
  function automatic bit roll_idle(bit sender);
    int pc = (phase % 4 == 0) ? 0 : (phase % 4 == 3) ? 27 :
             ((phase % 4 == 1) == sender) ? 46 : 0;
    return $urandom_range(0, 99) < pc;
  endfunction

  // Request driver, including APB writes and drain pauses.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (apb_busy) begin
        if (penable && pready) begin
          psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
          apb_busy <= 0;
          tail_wait <= TAIL_CYCLES;
        end else begin
          penable <= 1'b1;
        end
      end else if (s_axis_tvalid && !s_axis_tready) begin
        // Hold the request until it is taken.
      end else if (tail_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        if (expected_results.size() == 0) tail_wait <= tail_wait - 1;
      end else begin
        if (s_axis_tvalid) predict_table(pending_reqs.pop_front());
        if (pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (s_axis_tvalid == 0 && !stim_done) stim_done <= 1;
        end else if (pending_reqs[0].drain) begin
          s_axis_tvalid <= 1'b0;
          if (!s_axis_tvalid && expected_results.size() == 0) begin
            void'(pending_reqs.pop_front());
            phase <= phase + 1;
            tail_wait <= TAIL_CYCLES;
          end
        end else if (pending_reqs[0].is_cfg) begin
          s_axis_tvalid <= 1'b0;
          if (!s_axis_tvalid && expected_results.size() == 0) begin
            pool_limit = pending_reqs[0].cfg_val;
            psel <= 1'b1; pwrite <= 1'b1;
            paddr <= 3'(4 * lrupb_pkg::REG_FRAMES_IN_USE);
            pwdata <= 32'(pending_reqs[0].cfg_val);
            void'(pending_reqs.pop_front());
            apb_busy <= 1;
          end
        end else if (roll_idle(1)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_reqs[0].page;
          s_axis_tuser <= {pending_reqs[0].dirty, pending_reqs[0].op};
        end
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      m_axis_tready <= !roll_idle(0);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result page %0h", m_axis_tdata[31:0]));
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tuser[2:0] !== e.action)
            report_mismatch($sformatf("action %0d, want %0d", m_axis_tuser[2:0], e.action));
          if (m_axis_tdata[31:0] !== e.page)
            report_mismatch($sformatf("page %0h, want %0h", m_axis_tdata[31:0], e.page));
          if (m_axis_tdata[35:32] !== e.slot)
            report_mismatch($sformatf("slot %0d, want %0d", m_axis_tdata[35:32], e.slot));
          if (m_axis_tuser[3] !== e.hit)
            report_mismatch($sformatf("hit %0b, want %0b", m_axis_tuser[3], e.hit));
          if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, e.last));
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        tail_wait > 0 || apb_busy)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (stim_done) begin
      if (expected_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      if (error_count == 0 && expected_results.size() == 0)
        $display("Verification passed");
      else
        $display("Verification failed");
      $finish;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

>>> sim.f
hw/rtl/lrupb_pkg.sv
hw/rtl/lru_pinned_page_buffer_table.sv
verif/testbench.sv
